/* hw/rtl/sha256_stream_hash_top_macros.svh */
// Assertion macros shared by the checker.
`ifndef SHA256_STREAM_HASH_TOP_MACROS_SVH
`define SHA256_STREAM_HASH_TOP_MACROS_SVH
// Implication checked on every rising clock edge while out of reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/sha_pkg.sv */
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam t_word HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:0] CmdAbsorb = 1'b0;
    localparam logic [0:0] CmdFinish = 1'b1;
    localparam logic [7:0] PadByte   = 8'h80;

    // Byte source selected by the controller for a buffer write.
    typedef enum logic [1:0] {
        t_src_data = 2'd0,
        t_src_pad  = 2'd1,
        t_src_zero = 2'd2,
        t_src_len  = 2'd3
    } t_src;

    // Controller to datapath.
    typedef struct packed {
        logic       buf_we;
        t_src       buf_src;
        logic [5:0] buf_addr;
        logic [7:0] data;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       cmp_load;
        logic       cmp_round;
        logic [5:0] round;
        logic       cmp_fold;
        logic       hash_init;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [5:0] pos;
    } t_stat;

    function automatic t_word ror(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hw/rtl/sha_ctrl.sv */
module sha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cmd,
    input  logic [7:0]    i_data_byte,
    output logic          o_stall,
    input  logic          i_out_stall,
    output logic          o_valid,
    output logic [2:0]    o_word_index,
    output logic          o_last,
    output sha_pkg::t_cmd o_dp,
    input  sha_pkg::t_stat i_st
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_EMIT
    } t_state;

    t_state     r_state;
    logic [5:0] r_idx;      // pad byte address or round number
    logic       r_fin;      // current block ends a message
    logic       r_len_blk;  // this pad pass writes the length field
    logic [2:0] r_word;
    logic       r_valid;

    logic acc;
    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;

    always_comb begin
        o_dp           = '0;
        o_dp.buf_src   = t_src_data;
        o_dp.data      = i_data_byte;
        o_dp.round     = r_idx;
        o_dp.buf_addr  = i_st.pos;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_dp.buf_we  = 1'b1;
                    o_dp.buf_src = (i_cmd == CmdFinish) ? t_src_pad : t_src_data;
                    o_dp.cnt_inc = (i_cmd == CmdAbsorb);
                end
            end
            S_PAD: begin
                o_dp.buf_we   = 1'b1;
                o_dp.buf_addr = r_idx;
                o_dp.buf_src  = (r_len_blk && r_idx[5:3] == 3'd7) ? t_src_len : t_src_zero;
            end
            S_LOAD:  o_dp.cmp_load  = 1'b1;
            S_ROUND: o_dp.cmp_round = 1'b1;
            S_FOLD:  o_dp.cmp_fold  = 1'b1;
            S_EMIT: begin
                if (r_valid && !i_out_stall && r_word == 3'd7) begin
                    o_dp.hash_init = 1'b1;
                    o_dp.cnt_clr   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_fin     <= 1'b0;
            r_len_blk <= 1'b0;
            r_word    <= '0;
            r_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_cmd == CmdAbsorb) begin
                            r_fin <= 1'b0;
                            if (i_st.pos == 6'd63) r_state <= S_LOAD;
                        end else begin
                            r_fin     <= 1'b1;
                            r_len_blk <= (i_st.pos < 6'd56);
                            if (i_st.pos == 6'd63) begin
                                // pad byte filled the block; length goes in a new one
                                r_len_blk <= 1'b0;
                                r_state   <= S_LOAD;
                            end else begin
                                r_idx   <= i_st.pos + 6'd1;
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_idx <= r_idx + 6'd1;
                    if (r_idx == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_idx   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_idx <= r_idx + 6'd1;
                    if (r_idx == 6'd63) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (!r_len_blk) begin
                        // second padding block: zeros then length
                        r_len_blk <= 1'b1;
                        r_idx     <= '0;
                        r_state   <= S_PAD;
                    end else begin
                        r_word  <= '0;
                        r_valid <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_out_stall) begin
                        r_word <= r_word + 3'd1;
                        if (r_word == 3'd7) begin
                            r_valid <= 1'b0;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_word_index = r_word;
    assign o_last       = (r_word == 3'd7);
endmodule

/* hw/rtl/sha_dp.sv */
module sha_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha_pkg::t_cmd  i_dp,
    input  logic [2:0]     i_word_index,
    output sha_pkg::t_stat o_st,
    output logic [31:0]    o_digest_word
);
    import sha_pkg::*;

    t_word       r_buf [16];   // block buffer as 16 big-endian words
    t_word       r_w   [16];
    t_word       r_v   [8];
    t_word       r_h   [8];
    logic        r_h_ok;   // clear: hash state reads as initial values
    logic [63:0] r_cnt;

    logic [63:0] bits;
    logic [7:0]  n_byte;
    t_word       h_eff [8];
    t_word       w_new, w_cur, s0, s1, t1, t2;

    assign bits = {r_cnt[60:0], 3'b000};
    assign o_st.pos = r_cnt[5:0];

    always_comb begin
        unique case (i_dp.buf_src)
            t_src_data: n_byte = i_dp.data;
            t_src_pad:  n_byte = PadByte;
            t_src_zero: n_byte = 8'h00;
            t_src_len:  n_byte = bits[8*(7-i_dp.buf_addr[2:0]) +: 8];
            default:    n_byte = 8'h00;
        endcase
    end

    always_comb begin
        for (int j = 0; j < 8; j++) h_eff[j] = r_h_ok ? r_h[j] : HashInit[j];
    end

    // Schedule: window is a shift line, r_w[0] is the word for this round.
    always_comb begin
        s0    = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[i_dp.round] + w_cur;
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        // byte 0 of a word lands in bits 31..24
        if (i_dp.buf_we)
            r_buf[i_dp.buf_addr[5:2]][8*(3-i_dp.buf_addr[1:0]) +: 8] <= n_byte;
        if (i_dp.cmp_load) begin
            for (int j = 0; j < 16; j++) r_w[j] <= r_buf[j];
            for (int j = 0; j < 8; j++) r_v[j] <= h_eff[j];
        end
        if (i_dp.cmp_round) begin
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_dp.cmp_fold) begin
            for (int j = 0; j < 8; j++) r_h[j] <= h_eff[j] + r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_h_ok <= 1'b0;
        end else begin
            if (i_dp.cnt_clr)      r_cnt <= '0;
            else if (i_dp.cnt_inc) r_cnt <= r_cnt + 64'd1;
            if (i_dp.hash_init)     r_h_ok <= 1'b0;
            else if (i_dp.cmp_fold) r_h_ok <= 1'b1;
        end
    end

    assign o_digest_word = r_h[i_word_index];
endmodule

/* hw/rtl/sha256_stream_hash_top.sv */
// Channel | Dir | Handshake           | Payload
// input   | in  | i_valid / o_stall   | i_cmd, i_data_byte
// result  | out | o_valid / i_stall   | o_word_index, o_digest_word, o_last
// An absorb writes one buffer byte; the 64th byte of a block also starts
// compression (load, 64 rounds of the single round unit, fold).
// A finish pads at one buffer byte per cycle, compresses one or two blocks,
// then shows eight digest words, one per cycle unless stalled.
// Reset (synchronous, active low) restores the initial hash and clears the count.
// o_stall is high whenever a block is being padded, compressed or emitted.
module sha256_stream_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [0:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_word_index,
    output logic [31:0] o_digest_word,
    output logic [0:0]  o_last
);
    import sha_pkg::*;

    t_cmd  dp_cmd;
    t_stat dp_st;
    logic  last_w;

    // Controller sequences buffer writes, rounds and digest transfers.
    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_cmd        (i_cmd[0]),
        .i_data_byte  (i_data_byte),
        .o_stall      (o_stall),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .o_word_index (o_word_index),
        .o_last       (last_w),
        .o_dp         (dp_cmd),
        .i_st         (dp_st)
    );

    // Datapath: block buffer, schedule window, round unit, hash state.
    sha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp          (dp_cmd),
        .i_word_index  (o_word_index),
        .o_st          (dp_st),
        .o_digest_word (o_digest_word)
    );

    assign o_last = last_w;
endmodule

/* hw/rtl/sha_check.sv */
`include "sha256_stream_hash_top_macros.svh"
module sha_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_word_index,
    input logic [31:0] o_digest_word,
    input logic [0:0]  o_last
);
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid, o_last[0] == (o_word_index == 3'd7), "last flag mismatch")
    `SHA_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall, "input open during digest")
    `SHA_ASSERT_NEXT(a_word_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last[0], o_valid && o_word_index == $past(o_word_index) + 3'd1, "word order broken")
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_digest_word), "stalled word changed")
endmodule

bind sha256_stream_hash_top sha_check u_check (.*);
